[design/qsrm_pkg.sv]
// Shared constants, the sideband struct and width helpers for the quad scanline row mask.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package qsrm_pkg;

  localparam int DEF_MAX_BLOCK_WIDTH  = 64;
  localparam int DEF_MAX_BLOCK_HEIGHT = 1024;

  localparam int MIN_QUAD_SIZE = 5;
  localparam int XW            = 6;
  localparam int IN_YW         = 10;
  localparam int CROSS_W       = 7;
  localparam int QUOT_BITS     = 7;
  localparam int ROW_W         = 64;
  localparam int BW_W          = 7;
  localparam int BH_W          = 11;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  localparam logic [CROSS_W-1:0] CROSS_MAX = 7'd127;
  localparam logic [BW_W-1:0]    BW_RESET  = 7'd64;
  localparam logic [BH_W-1:0]    BH_RESET  = 11'd64;

  localparam logic REG_BLOCK_WIDTH  = 1'b0;
  localparam logic REG_BLOCK_HEIGHT = 1'b1;

  typedef struct packed {
    logic            undersize;
    logic            outer;
    logic [BW_W-1:0] width;
  } side_t;

  function automatic int coord_w(int max_h);
    int hb;
    hb = $clog2(max_h);
    return (hb > IN_YW) ? hb : IN_YW;
  endfunction

endpackage

`default_nettype wire

[design/qsrm_cfg.sv]
// Configuration register file with an APB-style port: block width and block height.
// Depends on qsrm_pkg for register codes, widths and reset values.
`default_nettype none

module qsrm_cfg import qsrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [BW_W-1:0]   block_width,
  output logic [BH_W-1:0]   block_height
);

  logic            wr_en;
  logic [BW_W-1:0] block_width_r;
  logic [BH_W-1:0] block_height_r;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_width_r  <= BW_RESET;
      block_height_r <= BH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BLOCK_WIDTH:  block_width_r  <= pwdata[BW_W-1:0];
        REG_BLOCK_HEIGHT: block_height_r <= pwdata[BH_W-1:0];
        default:          block_width_r  <= block_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_WIDTH:  prdata = APB_DW'(block_width_r);
      REG_BLOCK_HEIGHT: prdata = APB_DW'(block_height_r);
      default:          prdata = '0;
    endcase
  end

  assign block_width  = block_width_r;
  assign block_height = block_height_r;

endmodule

`default_nettype wire

[design/qsrm_edge.sv]
// Front stages: edge selection, the two cross products and the signed numerator per edge.
// Three register stages; depends on qsrm_pkg. Gives magnitude of numerator and denominator.
`default_nettype none

module qsrm_edge import qsrm_pkg::*; #(
  parameter int MAX_BLOCK_WIDTH  = DEF_MAX_BLOCK_WIDTH,
  parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [XW-1:0]    in_top_x,
  input  logic [IN_YW-1:0] in_left_y,
  input  logic [XW-1:0]    in_bottom_x,
  input  logic [IN_YW-1:0] in_right_y,
  input  logic [IN_YW-1:0] in_row_y,
  input  logic             in_outside_value,
  input  logic [BW_W-1:0]  cfg_width,
  input  logic [BH_W-1:0]  cfg_height,
  output logic             out_valid,
  output side_t            out_side,
  output logic [coord_w(MAX_BLOCK_HEIGHT)+8:0] out_mag [2],
  output logic [coord_w(MAX_BLOCK_HEIGHT)-1:0] out_den [2]
);

  localparam int YW   = coord_w(MAX_BLOCK_HEIGHT);
  localparam int SW   = YW + 1;
  localparam int XSW  = XW + 1;
  localparam int PW   = YW + 8;
  localparam int NW   = YW + 9;
  localparam int HEW  = $clog2(MAX_BLOCK_HEIGHT + 1);
  localparam int HCW  = (HEW > BH_W) ? HEW : BH_W;

  typedef enum logic [2:0] {
    EDGE_AB,
    EDGE_AD,
    EDGE_BC,
    EDGE_DC,
    EDGE_CB
  } edge_sel_t;

  logic [BW_W-1:0]       w_sat, w_m1;
  logic [HCW-1:0]        h_ext, h_sat, h_m1;
  logic [XW-1:0]         xd;
  logic [YW-1:0]         yc, yb, yd, yy;
  logic                  undersize;
  edge_sel_t             sel [2];
  logic [XW-1:0]         ex1 [2];
  logic [XW-1:0]         ex2 [2];
  logic [YW-1:0]         ey1 [2];
  logic [YW-1:0]         ey2 [2];
  logic signed [SW-1:0]  dy_nxt [2];
  logic signed [SW-1:0]  ry_nxt [2];
  logic signed [XSW-1:0] dx_nxt [2];
  side_t                 side_nxt;

  logic                  valid0_r, valid1_r, valid2_r;
  side_t                 side0_r, side1_r, side2_r;
  logic [XW-1:0]         x1_0_r [2];
  logic signed [SW-1:0]  dy0_r [2];
  logic signed [SW-1:0]  ry0_r [2];
  logic signed [XSW-1:0] dx0_r [2];
  logic [XW-1:0]         x1_1_r [2];
  logic signed [SW-1:0]  dy1_r [2];
  logic signed [PW-1:0]  p1_r [2];
  logic signed [PW-1:0]  p2_r [2];
  logic signed [PW-1:0]  p1_nxt [2];
  logic signed [PW-1:0]  p2_nxt [2];
  logic signed [NW-1:0]  num_c [2];
  logic signed [NW-1:0]  num_neg [2];
  logic signed [SW-1:0]  dy_neg [2];
  logic [NW-1:0]         mag_nxt [2];
  logic [YW-1:0]         den_nxt [2];
  logic [NW-1:0]         mag_r [2];
  logic [YW-1:0]         den_r [2];

  always_comb begin
    w_sat = (cfg_width > BW_W'(MAX_BLOCK_WIDTH)) ? BW_W'(MAX_BLOCK_WIDTH) : cfg_width;
    h_ext = HCW'(cfg_height);
    h_sat = (h_ext > HCW'(MAX_BLOCK_HEIGHT)) ? HCW'(MAX_BLOCK_HEIGHT) : h_ext;
    w_m1  = w_sat - 1'b1;
    h_m1  = h_sat - 1'b1;
    xd    = w_m1[XW-1:0];
    yc    = h_m1[YW-1:0];
    undersize = (w_sat < BW_W'(MIN_QUAD_SIZE)) || (h_sat < HCW'(MIN_QUAD_SIZE));
    yb    = YW'(in_left_y);
    yd    = YW'(in_right_y);
    yy    = YW'(in_row_y);

    if (in_left_y < in_right_y) begin
      if (in_row_y < in_left_y) begin
        sel[0] = EDGE_AB;
        sel[1] = EDGE_AD;
      end else if (in_row_y < in_right_y) begin
        sel[0] = EDGE_BC;
        sel[1] = EDGE_AD;
      end else begin
        sel[0] = EDGE_BC;
        sel[1] = EDGE_DC;
      end
    end else begin
      if (in_row_y < in_right_y) begin
        sel[0] = EDGE_AB;
        sel[1] = EDGE_AD;
      end else if (in_row_y < in_left_y) begin
        sel[0] = EDGE_AB;
        sel[1] = EDGE_DC;
      end else begin
        sel[0] = EDGE_CB;
        sel[1] = EDGE_DC;
      end
    end

    for (int l = 0; l < 2; l++) begin
      unique case (sel[l])
        EDGE_AB: begin
          ex1[l] = in_top_x; ey1[l] = '0; ex2[l] = '0; ey2[l] = yb;
        end
        EDGE_AD: begin
          ex1[l] = in_top_x; ey1[l] = '0; ex2[l] = xd; ey2[l] = yd;
        end
        EDGE_BC: begin
          ex1[l] = '0; ey1[l] = yb; ex2[l] = in_bottom_x; ey2[l] = yc;
        end
        EDGE_DC: begin
          ex1[l] = xd; ey1[l] = yd; ex2[l] = in_bottom_x; ey2[l] = yc;
        end
        EDGE_CB: begin
          ex1[l] = in_bottom_x; ey1[l] = yc; ex2[l] = '0; ey2[l] = yb;
        end
        default: begin
          ex1[l] = in_top_x; ey1[l] = '0; ex2[l] = '0; ey2[l] = yb;
        end
      endcase
      dy_nxt[l] = $signed({1'b0, ey2[l]}) - $signed({1'b0, ey1[l]});
      ry_nxt[l] = $signed({1'b0, yy}) - $signed({1'b0, ey1[l]});
      dx_nxt[l] = $signed({1'b0, ex2[l]}) - $signed({1'b0, ex1[l]});
    end

    side_nxt.undersize = undersize;
    side_nxt.outer     = in_outside_value;
    side_nxt.width     = w_sat;
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p1_nxt[l] = PW'($signed({1'b0, x1_0_r[l]})) * PW'(dy0_r[l]);
      p2_nxt[l] = PW'(ry0_r[l]) * PW'(dx0_r[l]);
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      num_c[l]   = NW'(p1_r[l]) + NW'(p2_r[l]);
      num_neg[l] = -num_c[l];
      dy_neg[l]  = -dy1_r[l];
      if (dy1_r[l] == '0) begin
        mag_nxt[l] = NW'(x1_1_r[l]);
        den_nxt[l] = YW'(1);
      end else begin
        mag_nxt[l] = num_c[l][NW-1] ? num_neg[l] : num_c[l];
        den_nxt[l] = dy1_r[l][SW-1] ? dy_neg[l][YW-1:0] : dy1_r[l][YW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid0_r <= in_valid;
      valid1_r <= valid0_r;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    side0_r <= side_nxt;
    side1_r <= side0_r;
    side2_r <= side1_r;
    for (int l = 0; l < 2; l++) begin
      x1_0_r[l] <= ex1[l];
      dy0_r[l]  <= dy_nxt[l];
      ry0_r[l]  <= ry_nxt[l];
      dx0_r[l]  <= dx_nxt[l];
      x1_1_r[l] <= x1_0_r[l];
      dy1_r[l]  <= dy0_r[l];
      p1_r[l]   <= p1_nxt[l];
      p2_r[l]   <= p2_nxt[l];
      mag_r[l]  <= mag_nxt[l];
      den_r[l]  <= den_nxt[l];
    end
  end

  assign out_valid = valid2_r;
  assign out_side  = side2_r;
  assign out_mag   = mag_r;
  assign out_den   = den_r;

endmodule

`default_nettype wire

[design/qsrm_div.sv]
// Two-lane pipelined restoring divider: a range stage, then one quotient bit per stage.
// Saturates a crossing whose quotient overflows to its maximum; depends on qsrm_pkg.
`default_nettype none

module qsrm_div import qsrm_pkg::*; #(
  parameter int YW = IN_YW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [YW+8:0]      in_mag [2],
  input  logic [YW-1:0]      in_den [2],
  output logic               out_valid,
  output side_t              out_side,
  output logic [CROSS_W-1:0] out_cross [2]
);

  localparam int NW = YW + 9;
  localparam int RW = YW + QUOT_BITS;

  logic                 valid_r [0:QUOT_BITS];
  side_t                side_r  [0:QUOT_BITS];
  logic                 ovf_r   [0:QUOT_BITS][0:1];
  logic [RW-1:0]        rem_r   [0:QUOT_BITS][0:1];
  logic [YW-1:0]        den_r   [0:QUOT_BITS][0:1];
  logic [QUOT_BITS-1:0] q_r     [0:QUOT_BITS][0:1];
  logic                 ovf_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf_nxt[l] = in_mag[l] >= NW'({in_den[l], {QUOT_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int l = 0; l < 2; l++) begin
      ovf_r[0][l] <= ovf_nxt[l];
      rem_r[0][l] <= in_mag[l][RW-1:0];
      den_r[0][l] <= in_den[l];
      q_r[0][l]   <= '0;
    end
  end

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
    localparam int K = QUOT_BITS - 1 - s;

    logic [RW-1:0] den_sh  [2];
    logic [RW:0]   trial   [2];
    logic [RW-1:0] rem_nxt [2];
    logic          bit_nxt [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        den_sh[l] = RW'(den_r[s][l]) << K;
        trial[l]  = {1'b0, rem_r[s][l]} - {1'b0, den_sh[l]};
        bit_nxt[l] = !trial[l][RW];
        rem_nxt[l] = bit_nxt[l] ? trial[l][RW-1:0] : rem_r[s][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= valid_r[s];
      end
    end

    always_ff @(posedge clk) begin
      side_r[s+1] <= side_r[s];
      for (int l = 0; l < 2; l++) begin
        ovf_r[s+1][l] <= ovf_r[s][l];
        rem_r[s+1][l] <= rem_nxt[l];
        den_r[s+1][l] <= den_r[s][l];
        q_r[s+1][l]   <= {q_r[s][l][QUOT_BITS-2:0], bit_nxt[l]};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      out_cross[l] = ovf_r[QUOT_BITS][l] ? CROSS_MAX : CROSS_W'(q_r[QUOT_BITS][l]);
    end
  end

  assign out_valid = valid_r[QUOT_BITS];
  assign out_side  = side_r[QUOT_BITS];

endmodule

`default_nettype wire

[design/qsrm_mask.sv]
// Output stage: builds the row mask from the two crossings and registers the result word.
// Depends on qsrm_pkg for the sideband struct and widths.
`default_nettype none

module qsrm_mask import qsrm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [CROSS_W-1:0] in_left,
  input  logic [CROSS_W-1:0] in_right,
  output logic               out_strobe,
  output logic [ROW_W-1:0]   out_row_mask,
  output logic [CROSS_W-1:0] out_left_cross_x,
  output logic [CROSS_W-1:0] out_right_cross_x
);

  logic [ROW_W-1:0]   covered, wmask, mask_nxt;
  logic [CROSS_W-1:0] left_nxt, right_nxt;
  logic               strobe_r;
  logic [ROW_W-1:0]   mask_r;
  logic [CROSS_W-1:0] left_r, right_r;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      if (in_left == in_right) begin
        covered[i] = CROSS_W'(i) == in_left;
      end else begin
        covered[i] = (CROSS_W'(i) >= in_left) && (CROSS_W'(i) < in_right);
      end
      wmask[i] = CROSS_W'(i) < in_side.width;
    end

    if (in_side.undersize) begin
      mask_nxt  = in_side.outer ? wmask : '0;
      left_nxt  = '0;
      right_nxt = '0;
    end else begin
      mask_nxt  = in_side.outer ? (wmask & ~covered) : (wmask & covered);
      left_nxt  = in_left;
      right_nxt = in_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_row_mask      = mask_r;
  assign out_left_cross_x  = left_r;
  assign out_right_cross_x = right_r;

endmodule

`default_nettype wire

[design/quad_scanline_row_mask.sv]
// Top level of the quad scanline row mask: configuration port, edge front end, divider, mask.
// Depends on qsrm_pkg, qsrm_cfg, qsrm_edge, qsrm_div and qsrm_mask.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   input   | start, busy          | in_top_x, in_left_y, in_bottom_x, in_right_y,
//           |                      | in_row_y, in_outside_value
//   result  | out_strobe           | out_row_mask, out_left_cross_x, out_right_cross_x
//   config  | psel, penable, pwrite| paddr, pwdata, prdata, pready
//
// One word is accepted in every cycle in which start is high; busy is always low.
// Each word passes twelve register stages: three in the edge front end, one range stage
// and seven quotient-bit stages in the divider, and the mask stage, which drives out_strobe.
// Reset clears the valid bits of every stage and restores both registers.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module quad_scanline_row_mask import qsrm_pkg::*; #(
  parameter int MAX_BLOCK_WIDTH  = DEF_MAX_BLOCK_WIDTH,
  parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [XW-1:0]      in_top_x,
  input  logic [IN_YW-1:0]   in_left_y,
  input  logic [XW-1:0]      in_bottom_x,
  input  logic [IN_YW-1:0]   in_right_y,
  input  logic [IN_YW-1:0]   in_row_y,
  input  logic               in_outside_value,
  output logic               out_strobe,
  output logic [ROW_W-1:0]   out_row_mask,
  output logic [CROSS_W-1:0] out_left_cross_x,
  output logic [CROSS_W-1:0] out_right_cross_x,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int YW = coord_w(MAX_BLOCK_HEIGHT);
  localparam int NW = YW + 9;

  logic               accept;
  logic [BW_W-1:0]    block_width;
  logic [BH_W-1:0]    block_height;
  logic               edge_valid;
  side_t              edge_side;
  logic [NW-1:0]      edge_mag [2];
  logic [YW-1:0]      edge_den [2];
  logic               div_valid;
  side_t              div_side;
  logic [CROSS_W-1:0] div_cross [2];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  qsrm_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .block_width  (block_width),
    .block_height (block_height)
  );

  qsrm_edge #(
    .MAX_BLOCK_WIDTH  (MAX_BLOCK_WIDTH),
    .MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT)
  ) u_edge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (accept),
    .in_top_x         (in_top_x),
    .in_left_y        (in_left_y),
    .in_bottom_x      (in_bottom_x),
    .in_right_y       (in_right_y),
    .in_row_y         (in_row_y),
    .in_outside_value (in_outside_value),
    .cfg_width        (block_width),
    .cfg_height       (block_height),
    .out_valid        (edge_valid),
    .out_side         (edge_side),
    .out_mag          (edge_mag),
    .out_den          (edge_den)
  );

  qsrm_div #(
    .YW (YW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edge_valid),
    .in_side   (edge_side),
    .in_mag    (edge_mag),
    .in_den    (edge_den),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_cross (div_cross)
  );

  qsrm_mask u_mask (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (div_valid),
    .in_side           (div_side),
    .in_left           (div_cross[0]),
    .in_right          (div_cross[1]),
    .out_strobe        (out_strobe),
    .out_row_mask      (out_row_mask),
    .out_left_cross_x  (out_left_cross_x),
    .out_right_cross_x (out_right_cross_x)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for quad_scanline_row_mask: it drives row words, predicts each
// row mask and both its edge crossings, and compares them with what the block produces.
// Depends on qsrm_pkg and the quad_scanline_row_mask RTL.
module tb;
  import qsrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 24;
  localparam int NUM_SETTINGS = 9;
  localparam int ROWS_PER_SETTING = 45;

  typedef struct packed {
    logic [XW-1:0]    top_x;
    logic [IN_YW-1:0] left_y;
    logic [XW-1:0]    bottom_x;
    logic [IN_YW-1:0] right_y;
    logic [IN_YW-1:0] row_y;
    logic             outside_value;
  } row_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   mask;
    logic [CROSS_W-1:0] left_x;
    logic [CROSS_W-1:0] right_x;
  } row_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [XW-1:0] in_top_x = '0;
  logic [IN_YW-1:0] in_left_y = '0;
  logic [XW-1:0] in_bottom_x = '0;
  logic [IN_YW-1:0] in_right_y = '0;
  logic [IN_YW-1:0] in_row_y = '0;
  logic in_outside_value = 1'b0;
  logic out_strobe;
  logic [ROW_W-1:0] out_row_mask;
  logic [CROSS_W-1:0] out_left_cross_x;
  logic [CROSS_W-1:0] out_right_cross_x;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  quad_scanline_row_mask uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_top_x(in_top_x), .in_left_y(in_left_y), .in_bottom_x(in_bottom_x),
    .in_right_y(in_right_y), .in_row_y(in_row_y), .in_outside_value(in_outside_value),
    .out_strobe(out_strobe), .out_row_mask(out_row_mask),
    .out_left_cross_x(out_left_cross_x), .out_right_cross_x(out_right_cross_x),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  row_item_t rows_to_send[$];
  row_word_t pending_rows[$];
  logic [BW_W-1:0] block_w_q = BW_RESET;
  logic [BH_W-1:0] block_h_q = BH_RESET;
  int gap_pct = 24;
  bit hold_feed = 1'b0;
  bit took_row = 1'b0;
  int mismatches = 0;
  int stall_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch in %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [CROSS_W-1:0] edge_crossing(input longint x1, input longint y1,
                                                       input longint x2, input longint y2,
                                                       input longint y);
    longint dy;
    longint v;
    dy = y2 - y1;
    if (dy == 0) begin
      v = x1;
    end else begin
      v = (x1 * dy + (y - y1) * (x2 - x1)) / dy;
    end
    if (v < 0) v = -v;
    if (v > longint'(CROSS_MAX)) v = longint'(CROSS_MAX);
    return v[CROSS_W-1:0];
  endfunction

  function automatic row_word_t fill_row(input row_item_t it);
    longint w, h, xa, yb, xc, yd, y, xd, yc;
    logic [ROW_W-1:0] full;
    logic [ROW_W-1:0] covered;
    logic [CROSS_W-1:0] xl, xr;
    row_word_t r;
    w = (block_w_q > DEF_MAX_BLOCK_WIDTH) ? DEF_MAX_BLOCK_WIDTH : longint'(block_w_q);
    h = (block_h_q > DEF_MAX_BLOCK_HEIGHT) ? DEF_MAX_BLOCK_HEIGHT : longint'(block_h_q);
    full = (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
    if (w < MIN_QUAD_SIZE || h < MIN_QUAD_SIZE) begin
      r.mask = it.outside_value ? full : '0;
      r.left_x = '0;
      r.right_x = '0;
      return r;
    end
    xa = it.top_x;
    yb = it.left_y;
    xc = it.bottom_x;
    yd = it.right_y;
    y = it.row_y;
    xd = w - 1;
    yc = h - 1;
    if (yb < yd) begin
      if (y < yb) begin
        xl = edge_crossing(xa, 0, 0, yb, y);
        xr = edge_crossing(xa, 0, xd, yd, y);
      end else if (y < yd) begin
        xl = edge_crossing(0, yb, xc, yc, y);
        xr = edge_crossing(xa, 0, xd, yd, y);
      end else begin
        xl = edge_crossing(0, yb, xc, yc, y);
        xr = edge_crossing(xd, yd, xc, yc, y);
      end
    end else begin
      if (y < yd) begin
        xl = edge_crossing(xa, 0, 0, yb, y);
        xr = edge_crossing(xa, 0, xd, yd, y);
      end else if (y < yb) begin
        xl = edge_crossing(xa, 0, 0, yb, y);
        xr = edge_crossing(xd, yd, xc, yc, y);
      end else begin
        xl = edge_crossing(xc, yc, 0, yb, y);
        xr = edge_crossing(xd, yd, xc, yc, y);
      end
    end
    covered = '0;
    if (xl == xr) begin
      if (xl < ROW_W) covered[xl] = 1'b1;
    end else begin
      for (int x = 0; x < ROW_W; x++) begin
        if (x >= xl && x < xr) covered[x] = 1'b1;
      end
    end
    covered &= full;
    r.mask = it.outside_value ? (full & ~covered) : covered;
    r.left_x = xl;
    r.right_x = xr;
    return r;
  endfunction

  function automatic row_item_t random_row();
    row_item_t it;
    int w, h;
    w = (block_w_q > DEF_MAX_BLOCK_WIDTH) ? DEF_MAX_BLOCK_WIDTH : int'(block_w_q);
    h = (block_h_q > DEF_MAX_BLOCK_HEIGHT) ? DEF_MAX_BLOCK_HEIGHT : int'(block_h_q);
    it.top_x = XW'($urandom_range(63));
    it.left_y = IN_YW'($urandom_range(1023));
    it.bottom_x = XW'($urandom_range(63));
    it.right_y = IN_YW'($urandom_range(1023));
    it.row_y = IN_YW'($urandom_range(1023));
    it.outside_value = 1'($urandom_range(1));
    if (w >= MIN_QUAD_SIZE && h >= MIN_QUAD_SIZE && $urandom_range(99) < 80) begin
      it.top_x = XW'($urandom_range(w - 2, 1));
      it.left_y = IN_YW'($urandom_range(h - 2, 1));
      it.bottom_x = XW'($urandom_range(w - 2, 1));
      it.right_y = IN_YW'($urandom_range(h - 2, 1));
      it.row_y = IN_YW'($urandom_range(h - 1, 0));
      if ($urandom_range(7) == 0) it.right_y = it.left_y;
    end
    return it;
  endfunction

  task automatic apb_xfer(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata);
    logic [APB_DW-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'(4 * idx);
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == REG_BLOCK_WIDTH) block_w_q = wdata[BW_W-1:0];
      else block_h_q = wdata[BH_W-1:0];
    end else begin
      want = (idx == REG_BLOCK_WIDTH) ? APB_DW'(block_w_q) : APB_DW'(block_h_q);
      if (prdata !== want) flag_mismatch("register read", 64'(prdata), 64'(want));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rows_to_send.size() != 0 || pending_rows.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    bit send;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took_row) void'(rows_to_send.pop_front());
      send = rows_to_send.size() != 0 && !hold_feed && $urandom_range(99) >= gap_pct;
      if (send) begin
        in_top_x <= rows_to_send[0].top_x;
        in_left_y <= rows_to_send[0].left_y;
        in_bottom_x <= rows_to_send[0].bottom_x;
        in_right_y <= rows_to_send[0].right_y;
        in_row_y <= rows_to_send[0].row_y;
        in_outside_value <= rows_to_send[0].outside_value;
      end
      start <= send;
    end
  end

  always @(posedge clk) begin
    row_word_t want;
    row_item_t seen;
    if (rst_n && out_strobe) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch("word with nothing pending", out_row_mask, '0);
      end else begin
        want = pending_rows.pop_front();
        if (out_row_mask !== want.mask)
          flag_mismatch("row_mask", out_row_mask, want.mask);
        if (out_left_cross_x !== want.left_x)
          flag_mismatch("left_cross_x", 64'(out_left_cross_x), 64'(want.left_x));
        if (out_right_cross_x !== want.right_x)
          flag_mismatch("right_cross_x", 64'(out_right_cross_x), 64'(want.right_x));
      end
    end
    if (rst_n && start && !busy) begin
      seen = '{in_top_x, in_left_y, in_bottom_x, in_right_y, in_row_y, in_outside_value};
      pending_rows.push_back(fill_row(seen));
    end
    took_row <= rst_n && start && !busy;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int set_w[NUM_SETTINGS];
    int set_h[NUM_SETTINGS];
    set_w = '{5, 64, 1, 64, 33, 127, 0, 17, 64};
    set_h = '{5, 1024, 64, 4, 100, 2047, 0, 700, 64};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    rows_to_send.push_back('{6'd1, 10'd1, 6'd1, 10'd1, 10'd0, 1'b0});
    rows_to_send.push_back('{6'd62, 10'd62, 6'd62, 10'd62, 10'd63, 1'b1});
    rows_to_send.push_back('{6'd31, 10'd20, 6'd40, 10'd45, 10'd0, 1'b0});
    rows_to_send.push_back('{6'd31, 10'd20, 6'd40, 10'd45, 10'd10, 1'b0});
    rows_to_send.push_back('{6'd31, 10'd20, 6'd40, 10'd45, 10'd30, 1'b1});
    rows_to_send.push_back('{6'd31, 10'd20, 6'd40, 10'd45, 10'd55, 1'b0});
    rows_to_send.push_back('{6'd31, 10'd45, 6'd40, 10'd20, 10'd10, 1'b1});
    rows_to_send.push_back('{6'd31, 10'd45, 6'd40, 10'd20, 10'd30, 1'b0});
    rows_to_send.push_back('{6'd31, 10'd45, 6'd40, 10'd20, 10'd55, 1'b1});
    rows_to_send.push_back('{6'd10, 10'd20, 6'd30, 10'd63, 10'd63, 1'b0});
    rows_to_send.push_back('{6'd10, 10'd63, 6'd30, 10'd20, 10'd63, 1'b1});
    rows_to_send.push_back('{6'd10, 10'd20, 6'd63, 10'd40, 10'd50, 1'b0});
    rows_to_send.push_back('{6'd0, 10'd30, 6'd0, 10'd30, 10'd15, 1'b1});
    rows_to_send.push_back('{6'd63, 10'd1, 6'd63, 10'd1022, 10'd1023, 1'b0});
    rows_to_send.push_back('{6'd5, 10'd10, 6'd50, 10'd20, 10'd1023, 1'b0});
    rows_to_send.push_back('{6'd30, 10'd10, 6'd2, 10'd5, 10'd1023, 1'b1});
    rows_to_send.push_back('{6'd10, 10'd1, 6'd62, 10'd1, 10'd1023, 1'b0});
    rows_to_send.push_back('{6'd20, 10'd1022, 6'd20, 10'd1022, 10'd500, 1'b1});
    rows_to_send.push_back('{6'd20, 10'd0, 6'd40, 10'd0, 10'd0, 1'b0});
    rows_to_send.push_back('{6'h2A, 10'h155, 6'h15, 10'h2AA, 10'h155, 1'b1});
    rows_to_send.push_back('{6'h15, 10'h2AA, 6'h2A, 10'h155, 10'h2AA, 1'b0});
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_drained();
      gap_pct = (s < 2) ? 24 : (s < 5) ? 75 : 0;
      apb_xfer(1'b1, REG_BLOCK_WIDTH, APB_DW'(set_w[s]));
      apb_xfer(1'b1, REG_BLOCK_HEIGHT, APB_DW'(set_h[s]));
      apb_xfer(1'b0, REG_BLOCK_WIDTH, '0);
      apb_xfer(1'b0, REG_BLOCK_HEIGHT, '0);
      @(posedge clk);
      for (int i = 0; i < ROWS_PER_SETTING; i++) rows_to_send.push_back(random_row());
      if (s == 1) begin
        while (rows_to_send.size() > ROWS_PER_SETTING / 2) @(posedge clk);
        hold_feed = 1'b1;
        @(posedge clk);
        while (pending_rows.size() != 0) @(posedge clk);
        hold_feed = 1'b0;
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
